### rtl/lbvhnb_pkg.sv
// ----------------------------------------------------------------------------
// LBVH internal node builder package
// Field widths, stream layouts, operation and status codes shared by the
// internal node builder.
// ----------------------------------------------------------------------------
package lbvhnb_pkg;

    // Default sizing of the code table.
    localparam int CAPACITY_DEFAULT  = 1024;
    localparam int CODE_BITS_DEFAULT = 32;

    // Field widths.
    localparam int COUNT_W  = 11;
    localparam int POS_W    = 10;
    localparam int MORTON_W = 32;
    localparam int OBJ_W    = 10;
    localparam int NODE_W   = 11;

    // Input stream layout (tdata, lowest bits first).
    localparam int S_POS_LSB    = 0;
    localparam int S_MORTON_LSB = S_POS_LSB + POS_W;
    localparam int S_OBJ_LSB    = S_MORTON_LSB + MORTON_W;
    localparam int S_USED_W     = S_OBJ_LSB + OBJ_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Result stream layout (tdata, lowest bits first).
    localparam int M_USED_W  = 3 * POS_W + 2 * (NODE_W + 1 + OBJ_W);
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_RESOLVE = 1'b1
    } opcode_t;

    typedef enum logic {
        STAT_OK        = 1'b0,
        STAT_BAD_INDEX = 1'b1
    } status_t;

endpackage

### rtl/lbvh_internal_node_builder.sv
// ----------------------------------------------------------------------------
// LBVH internal node builder
// Keeps a table of sorted Morton codes with object indices and resolves one
// radix tree internal node per request: key range, split and both children.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                     Direction  Contents
//  -------  ------------------------  ---------  ---------------------------------
//  s_       s_tvalid/tready/tdata/u   in         table write or node resolve
//  m_       m_tvalid/tready/tdata/u   out        one result per request
//  cfg_     cfg_valid/ready/data      in         code_count register
//
//  Every probe of the range and split searches is one read of the single
//  code memory port, and each search probe is issued in one state and
//  compared in the next. Node zero skips the range search, and a node
//  inside a run of equal codes scans the run instead, one code per cycle.
//  Reset (aresetn low, synchronous) clears the sequencer, the output valid
//  and sets code_count to 2; the code tables are not cleared.
//  The input is taken only while the sequencer is idle. A finished result
//  waits in the output register while the next request is accepted.
//
module lbvh_internal_node_builder #(
    parameter int CAPACITY  = lbvhnb_pkg::CAPACITY_DEFAULT,
    parameter int CODE_BITS = lbvhnb_pkg::CODE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] position, [41:10] morton_code, [51:42] object_index
    input  logic [lbvhnb_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] range_first, [19:10] range_last, [29:20] split_position,
    // [40:30] left_node, [41] left_is_leaf, [51:42] left_object,
    // [62:52] right_node, [63] right_is_leaf, [73:64] right_object
    output logic [lbvhnb_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] status
    output logic                              m_tuser,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lbvhnb_pkg::COUNT_W-1:0]    cfg_data
);
    import lbvhnb_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = ((AW > COUNT_W) ? AW : COUNT_W) + 3;
    localparam int CW = $clog2(CODE_BITS + 1);
    localparam logic [CW-1:0] CODE_LEN = CW'(CODE_BITS);
    localparam logic [CW-1:0] TOP_BIT  = CW'(CODE_BITS - 1);

    typedef logic signed [IW-1:0] idx_t;
    localparam idx_t CAP_I = idx_t'(CAPACITY);
    localparam idx_t ZERO  = idx_t'(0);
    localparam idx_t ONE   = idx_t'(1);
    localparam idx_t TWO   = idx_t'(2);

    typedef enum logic [17:0] {
        S_IDLE       = 18'b000000000000000001,
        S_GET_PREV   = 18'b000000000000000010,
        S_GET_CUR    = 18'b000000000000000100,
        S_GET_NEXT   = 18'b000000000000001000,
        S_SCAN       = 18'b000000000000010000,
        S_GROW       = 18'b000000000000100000,
        S_SRCH_ISSUE = 18'b000000000001000000,
        S_SRCH_EVAL  = 18'b000000000010000000,
        S_RANGE      = 18'b000000000100000000,
        S_SPLIT_A    = 18'b000000001000000000,
        S_SPLIT_B    = 18'b000000010000000000,
        S_SPLIT_C    = 18'b000000100000000000,
        S_SPL_ISSUE  = 18'b000001000000000000,
        S_SPL_EVAL   = 18'b000010000000000000,
        S_OBJ        = 18'b000100000000000000,
        S_OBJ_L      = 18'b001000000000000000,
        S_OBJ_R      = 18'b010000000000000000,
        S_EMIT       = 18'b100000000000000000
    } state_t;

    // Count of leading zeros over CODE_BITS bits; zero counts CODE_BITS.
    function automatic logic [CW-1:0] clz_f(input logic [CODE_BITS-1:0] x);
        logic [CW-1:0] cnt;
        logic          seen;
        cnt  = CODE_LEN;
        seen = 1'b0;
        for (int b = CODE_BITS - 1; b >= 0; b--) begin
            if (!seen && x[b]) begin
                cnt  = CW'(CODE_BITS - 1 - b);
                seen = 1'b1;
            end
        end
        return cnt;
    endfunction

    // True when the leading zero count of x exceeds p, i.e. the top p+1
    // bits of x are all zero.
    function automatic logic longer_f(input logic [CODE_BITS-1:0] x,
                                      input logic [CW-1:0]        p);
        logic [CODE_BITS-1:0] sh;
        logic                 res;
        sh  = '0;
        res = 1'b0;
        if (p < CODE_LEN) begin
            sh  = x >> (TOP_BIT - p);
            res = (sh == '0);
        end
        return res;
    endfunction

    // Code and object tables.
    logic [CODE_BITS-1:0] code_mem [CAPACITY];
    logic [OBJ_W-1:0]     obj_mem  [CAPACITY];

    state_t               state_reg,  state_next;
    logic [COUNT_W-1:0]   cfg_count_reg;
    logic [CODE_BITS-1:0] code_rd_reg;
    logic [OBJ_W-1:0]     obj_rd_reg;
    logic [CODE_BITS-1:0] key_reg,    key_next;
    logic [CODE_BITS-1:0] cprev_reg,  cprev_next;
    idx_t                 i_reg,      i_next;
    idx_t                 j_reg,      j_next;
    idx_t                 lmax_reg,   lmax_next;
    idx_t                 l_reg,      l_next;
    idx_t                 t_reg,      t_next;
    idx_t                 first_reg,  first_next;
    idx_t                 last_reg,   last_next;
    idx_t                 split_reg,  split_next;
    idx_t                 step_reg,   step_next;
    logic                 dneg_reg,   dneg_next;
    logic [CW-1:0]        dmin_reg,   dmin_next;
    logic [CW-1:0]        common_reg, common_next;
    logic [OBJ_W-1:0]     lobj_reg,   lobj_next;
    logic [OBJ_W-1:0]     robj_reg,   robj_next;
    logic                 plain_reg,  plain_next;
    status_t              status_reg, status_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic                 m_tuser_reg,  m_tuser_next;

    logic                 s_fire;
    opcode_t              in_op;
    idx_t                 in_pos;
    logic                 wr_en;
    logic                 rd_en;
    idx_t                 rd_idx;
    idx_t                 cnt_i;
    idx_t                 n_eff;
    idx_t                 n_m1;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_op  = opcode_t'(s_tuser);
    assign in_pos = idx_t'(s_tdata[S_POS_LSB +: POS_W]);
    assign wr_en  = s_fire && (in_op == OP_WRITE) && (in_pos < CAP_I);

    // Effective code count, held inside [2, CAPACITY].
    assign cnt_i = idx_t'(cfg_count_reg);
    assign n_eff = (cnt_i < TWO) ? TWO : ((cnt_i > CAP_I) ? CAP_I : cnt_i);
    assign n_m1  = n_eff - ONE;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            code_mem[in_pos[AW-1:0]] <= CODE_BITS'(s_tdata[S_MORTON_LSB +: MORTON_W]);
            obj_mem[in_pos[AW-1:0]]  <= s_tdata[S_OBJ_LSB +: OBJ_W];
        end
        if (rd_en) begin
            code_rd_reg <= code_mem[rd_idx[AW-1:0]];
            obj_rd_reg  <= obj_mem[rd_idx[AW-1:0]];
        end
    end

    always_comb begin
        idx_t          k;
        idx_t          off;
        idx_t          lm2;
        idx_t          st;
        idx_t          jn;
        idx_t          lnode;
        idx_t          rnode;
        logic [CW-1:0] pn;
        logic [CW-1:0] pp;
        logic          lleaf;
        logic          rleaf;

        state_next    = state_reg;
        key_next      = key_reg;
        cprev_next    = cprev_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        lmax_next     = lmax_reg;
        l_next        = l_reg;
        t_next        = t_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        split_next    = split_reg;
        step_next     = step_reg;
        dneg_next     = dneg_reg;
        dmin_next     = dmin_reg;
        common_next   = common_reg;
        lobj_next     = lobj_reg;
        robj_next     = robj_reg;
        plain_next    = plain_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rd_en         = 1'b0;
        rd_idx        = i_reg;

        k     = '0;
        off   = '0;
        lm2   = '0;
        st    = '0;
        jn    = '0;
        pn    = '0;
        pp    = '0;
        lleaf = (first_reg == split_reg);
        rleaf = (last_reg == split_reg + ONE);
        lnode = lleaf ? (n_m1 + split_reg) : split_reg;
        rnode = rleaf ? (n_m1 + split_reg + ONE) : (split_reg + ONE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    i_next      = in_pos;
                    plain_next  = 1'b0;
                    status_next = STAT_OK;
                    if (in_op == OP_WRITE) begin
                        plain_next  = 1'b1;
                        status_next = (in_pos < CAP_I) ? STAT_OK : STAT_BAD_INDEX;
                        state_next  = S_EMIT;
                    end else if (in_pos >= n_m1) begin
                        plain_next  = 1'b1;
                        status_next = STAT_BAD_INDEX;
                        state_next  = S_EMIT;
                    end else if (in_pos == '0) begin
                        first_next = '0;
                        last_next  = n_m1;
                        state_next = S_SPLIT_A;
                    end else begin
                        rd_en      = 1'b1;
                        rd_idx     = in_pos - ONE;
                        state_next = S_GET_PREV;
                    end
                end
            end
            S_GET_PREV: begin
                cprev_next = code_rd_reg;
                rd_en      = 1'b1;
                rd_idx     = i_reg;
                state_next = S_GET_CUR;
            end
            S_GET_CUR: begin
                key_next   = code_rd_reg;
                rd_en      = 1'b1;
                rd_idx     = i_reg + ONE;
                state_next = S_GET_NEXT;
            end
            S_GET_NEXT: begin
                if ((cprev_reg == key_reg) && (key_reg == code_rd_reg)) begin
                    // A run of equal codes: walk forward to its end.
                    jn = i_reg + TWO;
                    if (jn < n_eff) begin
                        rd_en      = 1'b1;
                        rd_idx     = jn;
                        j_next     = jn;
                        state_next = S_SCAN;
                    end else begin
                        first_next = i_reg;
                        last_next  = i_reg + ONE;
                        state_next = S_SPLIT_A;
                    end
                end else begin
                    pn        = clz_f(key_reg ^ code_rd_reg);
                    pp        = clz_f(key_reg ^ cprev_reg);
                    // On a tie the range grows backward.
                    dneg_next = !(pn > pp);
                    dmin_next = (pn > pp) ? pp : pn;
                    lmax_next = TWO;
                    l_next    = '0;
                    k         = (pn > pp) ? (i_reg + TWO) : (i_reg - TWO);
                    if ((k >= ZERO) && (k < n_eff)) begin
                        rd_en      = 1'b1;
                        rd_idx     = k;
                        state_next = S_GROW;
                    end else begin
                        t_next     = ONE;
                        state_next = S_SRCH_ISSUE;
                    end
                end
            end
            S_SCAN: begin
                if (code_rd_reg == key_reg) begin
                    jn = j_reg + ONE;
                    if (jn < n_eff) begin
                        rd_en  = 1'b1;
                        rd_idx = jn;
                        j_next = jn;
                    end else begin
                        first_next = i_reg;
                        last_next  = j_reg;
                        state_next = S_SPLIT_A;
                    end
                end else begin
                    first_next = i_reg;
                    last_next  = j_reg - ONE;
                    state_next = S_SPLIT_A;
                end
            end
            S_GROW: begin
                if (longer_f(key_reg ^ code_rd_reg, dmin_reg)) begin
                    lm2       = lmax_reg <<< 1;
                    lmax_next = lm2;
                    k         = dneg_reg ? (i_reg - lm2) : (i_reg + lm2);
                    if ((k >= ZERO) && (k < n_eff)) begin
                        rd_en  = 1'b1;
                        rd_idx = k;
                    end else begin
                        t_next     = lmax_reg;
                        state_next = S_SRCH_ISSUE;
                    end
                end else begin
                    t_next     = lmax_reg >>> 1;
                    state_next = S_SRCH_ISSUE;
                end
            end
            S_SRCH_ISSUE: begin
                off = l_reg + t_reg;
                k   = dneg_reg ? (i_reg - off) : (i_reg + off);
                if ((k >= ZERO) && (k < n_eff)) begin
                    rd_en      = 1'b1;
                    rd_idx     = k;
                    state_next = S_SRCH_EVAL;
                end else begin
                    t_next = t_reg >>> 1;
                    if ((t_reg >>> 1) == '0) begin
                        state_next = S_RANGE;
                    end
                end
            end
            S_SRCH_EVAL: begin
                if (longer_f(key_reg ^ code_rd_reg, dmin_reg)) begin
                    l_next = l_reg + t_reg;
                end
                t_next     = t_reg >>> 1;
                state_next = ((t_reg >>> 1) == '0) ? S_RANGE : S_SRCH_ISSUE;
            end
            S_RANGE: begin
                if (dneg_reg) begin
                    first_next = i_reg - l_reg;
                    last_next  = i_reg;
                end else begin
                    first_next = i_reg;
                    last_next  = i_reg + l_reg;
                end
                state_next = S_SPLIT_A;
            end
            S_SPLIT_A: begin
                if (first_reg >= last_reg) begin
                    split_next = first_reg;
                    state_next = S_OBJ;
                end else begin
                    rd_en      = 1'b1;
                    rd_idx     = first_reg;
                    state_next = S_SPLIT_B;
                end
            end
            S_SPLIT_B: begin
                key_next   = code_rd_reg;
                rd_en      = 1'b1;
                rd_idx     = last_reg;
                state_next = S_SPLIT_C;
            end
            S_SPLIT_C: begin
                common_next = clz_f(key_reg ^ code_rd_reg);
                split_next  = first_reg;
                step_next   = last_reg - first_reg;
                if (clz_f(key_reg ^ code_rd_reg) == CODE_LEN) begin
                    state_next = S_OBJ;
                end else begin
                    state_next = S_SPL_ISSUE;
                end
            end
            S_SPL_ISSUE: begin
                if (step_reg > ONE) begin
                    st        = (step_reg + ONE) >>> 1;
                    step_next = st;
                    jn        = split_reg + st;
                    if (jn < last_reg) begin
                        rd_en      = 1'b1;
                        rd_idx     = jn;
                        j_next     = jn;
                        state_next = S_SPL_EVAL;
                    end
                end else begin
                    state_next = S_OBJ;
                end
            end
            S_SPL_EVAL: begin
                if (longer_f(key_reg ^ code_rd_reg, common_reg)) begin
                    split_next = j_reg;
                end
                state_next = S_SPL_ISSUE;
            end
            S_OBJ: begin
                rd_en      = 1'b1;
                rd_idx     = split_reg;
                state_next = S_OBJ_L;
            end
            S_OBJ_L: begin
                lobj_next  = lleaf ? obj_rd_reg : '0;
                rd_en      = 1'b1;
                rd_idx     = split_reg + ONE;
                state_next = S_OBJ_R;
            end
            S_OBJ_R: begin
                robj_next  = rleaf ? obj_rd_reg : '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    if (plain_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {{M_PAD_W{1'b0}},
                                        robj_reg, rleaf, rnode[NODE_W-1:0],
                                        lobj_reg, lleaf, lnode[NODE_W-1:0],
                                        split_reg[POS_W-1:0],
                                        last_reg[POS_W-1:0],
                                        first_reg[POS_W-1:0]};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            cfg_count_reg <= COUNT_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                cfg_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        cprev_reg   <= cprev_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        lmax_reg    <= lmax_next;
        l_reg       <= l_next;
        t_reg       <= t_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        split_reg   <= split_next;
        step_reg    <= step_next;
        dneg_reg    <= dneg_next;
        dmin_reg    <= dmin_next;
        common_reg  <= common_next;
        lobj_reg    <= lobj_next;
        robj_reg    <= robj_next;
        plain_reg   <= plain_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // An accepted request always takes the sequencer out of idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer still idle after accepting a request");

    // The growth bound doubles from two, so it stays a power of two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GROW) |-> $onehot(lmax_reg))
        else $error("range growth bound is not a power of two");

    // The binary search step is halved from a power of two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH_EVAL) |-> $onehot(t_reg))
        else $error("range search step is not a power of two");

    // Every split candidate lies strictly inside the node's range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SPL_EVAL) |-> (j_reg > first_reg) && (j_reg < last_reg))
        else $error("split candidate outside the key range");

endmodule
